// ===== rtl/qfe_pkg.sv =====
// Package for the quotient filter engine: types, codes and constants.
`default_nettype none
package qfe_pkg;

    localparam int MAX_QUOTIENT_BITS  = 10;
    localparam int MAX_REMAINDER_BITS = 20;

    localparam logic [3:0] CFG_Q_RESET = 4'd10;
    localparam logic [4:0] CFG_R_RESET = 5'd20;

    // slot flag positions
    localparam int FLAG_OCC   = 0;
    localparam int FLAG_CONT  = 1;
    localparam int FLAG_SHIFT = 2;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_LOOKUP = 2'd1,
        ACT_REMOVE = 2'd2,
        ACT_CLEAR  = 2'd3
    } action_t;

    typedef enum logic [3:0] {
        OUT_INSERTED  = 4'd0,
        OUT_DUPLICATE = 4'd1,
        OUT_FULL      = 4'd2,
        OUT_FOUND     = 4'd3,
        OUT_ABSENT    = 4'd4,
        OUT_REMOVED   = 4'd5,
        OUT_NOTHING   = 4'd6,
        OUT_RANGE     = 4'd7,
        OUT_CLEARED   = 4'd8
    } outcome_t;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_T,
        ST_TW,
        ST_L1,
        ST_L1W,
        ST_L2,
        ST_L3,
        ST_L3W,
        ST_L4,
        ST_L4W,
        ST_SC,
        ST_SCW,
        ST_IP,
        ST_ICONT,
        ST_ICONTW,
        ST_P,
        ST_PW,
        ST_RN,
        ST_RNW,
        ST_PO0,
        ST_PO0W,
        ST_PO1,
        ST_PO1W,
        ST_PO2,
        ST_PO2W,
        ST_HD,
        ST_HDW,
        ST_DONE
    } state_t;

endpackage
`default_nettype wire

// ===== rtl/qfe_ram.sv =====
// Generic simple dual-port RAM with registered read.
`default_nettype none
module qfe_ram #(
    parameter int WIDTH = 23,
    parameter int DEPTH = 1024
) (
    input  wire                      clk,
    input  wire                      we,
    input  wire [$clog2(DEPTH)-1:0]  waddr,
    input  wire [WIDTH-1:0]          wdata,
    input  wire [$clog2(DEPTH)-1:0]  raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== rtl/quotient_filter_engine_unit.sv =====
// Quotient filter engine: slot table in one RAM, walked by a read-modify-write sequencer.
//
// Input channel (in_valid/in_ready) takes one word: action and 64-bit hash. Output channel
// (out_valid/out_ready) returns one word per item: answer, outcome and entry_count.
// Configuration is a plain write port (cfg_write_en, cfg_index, cfg_data); any write
// restarts the clearing sweep and zeroes the count.
// One item at a time. Every slot access is a registered RAM read, then a step that uses
// the data, so the work of lookup/insert/remove grows with the slots walked by run location,
// scan, shift or slide. Clear writes one slot per cycle.
// After reset, and after a config write, a sweep clears the table; no item is accepted
// until it ends.
// The result sits in an output register; while the receiver stalls, the next item is
// still accepted and worked, and waits in its final step until the register frees.
`default_nettype none
module quotient_filter_engine_unit #(
    parameter int MAX_QUOTIENT_BITS  = qfe_pkg::MAX_QUOTIENT_BITS,
    parameter int MAX_REMAINDER_BITS = qfe_pkg::MAX_REMAINDER_BITS
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          cfg_write_en,
    input  wire                          cfg_index,
    input  wire [4:0]                    cfg_data,
    input  wire                          in_valid,
    output logic                         in_ready,
    input  wire [1:0]                    action,
    input  wire [63:0]                   hash,
    output logic                         out_valid,
    input  wire                          out_ready,
    output logic                         answer,
    output logic [3:0]                   outcome,
    output logic [MAX_QUOTIENT_BITS:0]   entry_count
);

    localparam int AW    = MAX_QUOTIENT_BITS;
    localparam int CW    = MAX_QUOTIENT_BITS + 1;
    localparam int RB    = MAX_REMAINDER_BITS;
    localparam int EW    = MAX_REMAINDER_BITS + 3;
    localparam int DEPTH = 1 << MAX_QUOTIENT_BITS;
    localparam int QW    = $clog2(MAX_QUOTIENT_BITS + 1);
    localparam int RW    = $clog2(MAX_REMAINDER_BITS + 1);

    qfe_pkg::state_t   state_reg, state_next;
    qfe_pkg::action_t  act_reg, act_next;
    qfe_pkg::outcome_t code_reg, code_next;
    logic              ans_reg, ans_next;

    logic [3:0]    q_reg, q_next;
    logic [4:0]    r_reg, r_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic          clr_pend_reg, clr_pend_next;

    logic [AW-1:0] fq_reg, fq_next;
    logic [RB-1:0] fr_reg, fr_next;
    logic [EW-1:0] t_reg, t_next;
    logic [EW-1:0] cur_reg, cur_next;
    logic [EW-1:0] nv_reg, nv_next;
    logic [AW-1:0] b_reg, b_next;
    logic [AW-1:0] s_reg, s_next;
    logic [AW-1:0] start_reg, start_next;
    logic [AW-1:0] sp_reg, sp_next;
    logic [AW-1:0] orig_reg, orig_next;
    logic [AW-1:0] quot_reg, quot_next;
    logic [CW-1:0] k_reg, k_next;
    logic [CW-1:0] j_reg, j_next;
    logic          first_reg, first_next;
    logic          head_reg, head_next;

    logic          out_valid_reg, out_valid_next;
    logic          answer_reg, answer_next;
    logic [3:0]    outcome_reg, outcome_next;
    logic [CW-1:0] entry_count_reg, entry_count_next;

    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [EW-1:0] ram_wdata, ram_rdata;

    logic [QW-1:0] eff_q;
    logic [RW-1:0] eff_r;
    logic [CW-1:0] n_slots;
    logic [AW-1:0] mask;
    logic [RB:0]   r_one;
    logic [RB-1:0] r_mask;
    logic [RB-1:0] fr_in;
    logic [AW-1:0] fq_in;
    logic [7:0]    sh;
    logic          high_nz;
    logic          in_fire;
    logic          out_free;

    logic rd_occ, rd_cont, rd_shf, rd_empty;
    logic k_lt_n, j_lt_n, k1_lt_n;
    logic stop_cont, sc_hit, sc_gt, sc_adv, scan_more, sc_head;
    logic po_term, po_runstart;
    logic t_occ, full;
    logic clr_last;
    logic [CW-1:0] count_upd;

    qfe_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    function automatic logic [AW-1:0] nxt(input logic [AW-1:0] i, input logic [AW-1:0] m);
        nxt = AW'(i + 1'b1) & m;
    endfunction

    function automatic logic [AW-1:0] prv(input logic [AW-1:0] i, input logic [AW-1:0] m);
        prv = AW'(i - 1'b1) & m;
    endfunction

    // effective widths: zero reads as one, too large reads as the maximum
    always_comb
    begin
        if (q_reg == 4'd0)
            eff_q = QW'(1);
        else if (32'(q_reg) > MAX_QUOTIENT_BITS)
            eff_q = QW'(MAX_QUOTIENT_BITS);
        else
            eff_q = QW'(q_reg);
        if (r_reg == 5'd0)
            eff_r = RW'(1);
        else if (32'(r_reg) > MAX_REMAINDER_BITS)
            eff_r = RW'(MAX_REMAINDER_BITS);
        else
            eff_r = RW'(r_reg);
    end

    assign n_slots = CW'(1) << eff_q;
    assign mask    = AW'(n_slots - 1'b1);
    assign r_one   = (RB + 1)'(1) << eff_r;
    assign r_mask  = RB'(r_one - 1'b1);
    assign fr_in   = hash[RB-1:0] & r_mask;
    assign fq_in   = AW'(hash >> eff_r) & mask;
    assign sh      = 8'(eff_q) + 8'(eff_r);
    assign high_nz = (hash >> sh) != 64'd0;

    assign in_ready = (state_reg == qfe_pkg::ST_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    assign rd_occ   = ram_rdata[qfe_pkg::FLAG_OCC];
    assign rd_cont  = ram_rdata[qfe_pkg::FLAG_CONT];
    assign rd_shf   = ram_rdata[qfe_pkg::FLAG_SHIFT];
    assign rd_empty = ram_rdata[2:0] == 3'b000;

    assign k_lt_n  = k_reg < n_slots;
    assign j_lt_n  = j_reg < n_slots;
    assign k1_lt_n = (k_reg + 1'b1) < n_slots;

    // scan step: first slot of the run skips the continuation test
    assign stop_cont = !first_reg && !rd_cont;
    assign sc_hit    = !stop_cont && (ram_rdata[EW-1:3] == fr_reg);
    assign sc_gt     = !stop_cont && !sc_hit && (ram_rdata[EW-1:3] > fr_reg);
    assign sc_adv    = !stop_cont && !sc_hit && !sc_gt;
    assign scan_more = sc_adv && k1_lt_n;
    assign sc_head   = !rd_cont && (rd_occ || rd_shf);

    assign po_runstart = !rd_cont && (rd_occ || rd_shf);
    assign po_term     = rd_empty || (rd_occ && !rd_cont && !rd_shf) || (sp_reg == orig_reg);

    assign t_occ    = t_reg[qfe_pkg::FLAG_OCC];
    assign full     = count_reg >= n_slots;
    assign clr_last = clr_reg == mask;

    always_comb
    begin
        case (code_reg)
            qfe_pkg::OUT_INSERTED: count_upd = count_reg + 1'b1;
            qfe_pkg::OUT_REMOVED:  count_upd = count_reg - 1'b1;
            default:               count_upd = count_reg;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            qfe_pkg::ST_CLEAR:
                if (clr_last)
                    state_next = clr_pend_reg ? qfe_pkg::ST_DONE : qfe_pkg::ST_IDLE;
            qfe_pkg::ST_IDLE:
                if (in_fire)
                begin
                    if (action == qfe_pkg::ACT_CLEAR)
                        state_next = qfe_pkg::ST_CLEAR;
                    else if (action == qfe_pkg::ACT_REMOVE && high_nz)
                        state_next = qfe_pkg::ST_DONE;
                    else
                        state_next = qfe_pkg::ST_T;
                end
            qfe_pkg::ST_T:   state_next = qfe_pkg::ST_TW;
            qfe_pkg::ST_TW:
                case (act_reg)
                    qfe_pkg::ACT_INSERT:
                        state_next = (full || (ram_rdata[2:0] == 3'b000)) ?
                                     qfe_pkg::ST_DONE : qfe_pkg::ST_L1;
                    qfe_pkg::ACT_LOOKUP:
                        state_next = rd_occ ? qfe_pkg::ST_L1 : qfe_pkg::ST_DONE;
                    default:
                        state_next = (rd_occ && count_reg != '0) ?
                                     qfe_pkg::ST_L1 : qfe_pkg::ST_DONE;
                endcase
            qfe_pkg::ST_L1:  state_next = qfe_pkg::ST_L1W;
            qfe_pkg::ST_L1W: state_next = (k_lt_n && rd_shf) ? qfe_pkg::ST_L1 : qfe_pkg::ST_L2;
            qfe_pkg::ST_L2:
                if (k_lt_n && b_reg != fq_reg)
                    state_next = qfe_pkg::ST_L3;
                else if (act_reg == qfe_pkg::ACT_INSERT && !t_occ)
                    state_next = qfe_pkg::ST_IP;
                else
                    state_next = qfe_pkg::ST_SC;
            qfe_pkg::ST_L3:  state_next = qfe_pkg::ST_L3W;
            qfe_pkg::ST_L3W: state_next = (j_lt_n && rd_cont) ? qfe_pkg::ST_L3 : qfe_pkg::ST_L4;
            qfe_pkg::ST_L4:  state_next = qfe_pkg::ST_L4W;
            qfe_pkg::ST_L4W: state_next = (j_lt_n && !rd_occ) ? qfe_pkg::ST_L4 : qfe_pkg::ST_L2;
            qfe_pkg::ST_SC:  state_next = qfe_pkg::ST_SCW;
            qfe_pkg::ST_SCW:
                if (scan_more)
                    state_next = qfe_pkg::ST_SC;
                else if (sc_hit)
                begin
                    if (act_reg == qfe_pkg::ACT_REMOVE)
                        state_next = sc_head ? qfe_pkg::ST_RN : qfe_pkg::ST_PO0;
                    else
                        state_next = qfe_pkg::ST_DONE;
                end
                else
                    state_next = (act_reg == qfe_pkg::ACT_INSERT) ?
                                 qfe_pkg::ST_IP : qfe_pkg::ST_DONE;
            qfe_pkg::ST_IP:
                state_next = (t_occ && s_reg == start_reg) ? qfe_pkg::ST_ICONT : qfe_pkg::ST_P;
            qfe_pkg::ST_ICONT:  state_next = qfe_pkg::ST_ICONTW;
            qfe_pkg::ST_ICONTW: state_next = qfe_pkg::ST_P;
            qfe_pkg::ST_P:      state_next = qfe_pkg::ST_PW;
            qfe_pkg::ST_PW:
                state_next = (rd_empty || !k1_lt_n) ? qfe_pkg::ST_DONE : qfe_pkg::ST_P;
            qfe_pkg::ST_RN:   state_next = qfe_pkg::ST_RNW;
            qfe_pkg::ST_RNW:  state_next = qfe_pkg::ST_PO0;
            qfe_pkg::ST_PO0:  state_next = qfe_pkg::ST_PO0W;
            qfe_pkg::ST_PO0W: state_next = qfe_pkg::ST_PO1;
            qfe_pkg::ST_PO1:  state_next = qfe_pkg::ST_PO1W;
            qfe_pkg::ST_PO1W:
                if (po_term)
                    state_next = head_reg ? qfe_pkg::ST_HD : qfe_pkg::ST_DONE;
                else
                    state_next = po_runstart ? qfe_pkg::ST_PO2 : qfe_pkg::ST_PO1;
            qfe_pkg::ST_PO2:  state_next = qfe_pkg::ST_PO2W;
            qfe_pkg::ST_PO2W:
                state_next = (j_lt_n && !rd_occ) ? qfe_pkg::ST_PO2 : qfe_pkg::ST_PO1;
            qfe_pkg::ST_HD:   state_next = qfe_pkg::ST_HDW;
            qfe_pkg::ST_HDW:  state_next = qfe_pkg::ST_DONE;
            qfe_pkg::ST_DONE:
                if (out_free)
                    state_next = qfe_pkg::ST_IDLE;
            default: state_next = qfe_pkg::ST_IDLE;
        endcase
        if (cfg_write_en)
            state_next = qfe_pkg::ST_CLEAR;
    end

    // datapath, RAM port and result register
    always_comb
    begin
        logic [EW-1:0] old_v;
        logic [EW-1:0] cm_v;
        logic [EW-1:0] upd_v;

        act_next         = act_reg;
        code_next        = code_reg;
        ans_next         = ans_reg;
        q_next           = q_reg;
        r_next           = r_reg;
        count_next       = count_reg;
        clr_next         = clr_reg;
        clr_pend_next    = clr_pend_reg;
        fq_next          = fq_reg;
        fr_next          = fr_reg;
        t_next           = t_reg;
        cur_next         = cur_reg;
        nv_next          = nv_reg;
        b_next           = b_reg;
        s_next           = s_reg;
        start_next       = start_reg;
        sp_next          = sp_reg;
        orig_next        = orig_reg;
        quot_next        = quot_reg;
        k_next           = k_reg;
        j_next           = j_reg;
        first_next       = first_reg;
        head_next        = head_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        answer_next      = answer_reg;
        outcome_next     = outcome_reg;
        entry_count_next = entry_count_reg;
        ram_we           = 1'b0;
        ram_waddr        = s_reg;
        ram_wdata        = '0;
        ram_raddr        = s_reg;
        old_v            = ram_rdata;
        cm_v             = cur_reg;
        upd_v            = ram_rdata;

        case (state_reg)
            qfe_pkg::ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                clr_next  = clr_reg + 1'b1;
            end
            qfe_pkg::ST_IDLE:
                if (in_fire)
                begin
                    act_next  = qfe_pkg::action_t'(action);
                    fq_next   = fq_in;
                    fr_next   = fr_in;
                    quot_next = fq_in;
                    cur_next  = {fr_in, 3'b000};
                    if (action == qfe_pkg::ACT_CLEAR)
                    begin
                        clr_next      = '0;
                        clr_pend_next = 1'b1;
                        count_next    = '0;
                        code_next     = qfe_pkg::OUT_CLEARED;
                        ans_next      = 1'b1;
                    end
                    else if (action == qfe_pkg::ACT_REMOVE && high_nz)
                    begin
                        code_next = qfe_pkg::OUT_RANGE;
                        ans_next  = 1'b0;
                    end
                end
            qfe_pkg::ST_T: ram_raddr = fq_reg;
            qfe_pkg::ST_TW:
            begin
                t_next = ram_rdata;
                b_next = fq_reg;
                k_next = '0;
                case (act_reg)
                    qfe_pkg::ACT_INSERT:
                        if (full)
                        begin
                            code_next = qfe_pkg::OUT_FULL;
                            ans_next  = 1'b0;
                        end
                        else if (rd_empty)
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = fq_reg;
                            ram_wdata = cur_reg | EW'(1);
                            code_next = qfe_pkg::OUT_INSERTED;
                            ans_next  = 1'b1;
                        end
                        else if (!rd_occ)
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = fq_reg;
                            ram_wdata = ram_rdata | EW'(1);
                        end
                    qfe_pkg::ACT_LOOKUP:
                    begin
                        code_next = qfe_pkg::OUT_ABSENT;
                        ans_next  = 1'b0;
                    end
                    default:
                    begin
                        code_next = qfe_pkg::OUT_NOTHING;
                        ans_next  = 1'b1;
                    end
                endcase
            end
            qfe_pkg::ST_L1: ram_raddr = b_reg;
            qfe_pkg::ST_L1W:
                if (k_lt_n && rd_shf)
                begin
                    b_next = prv(b_reg, mask);
                    k_next = k_reg + 1'b1;
                end
                else
                begin
                    s_next = b_reg;
                    k_next = '0;
                end
            qfe_pkg::ST_L2:
                if (k_lt_n && b_reg != fq_reg)
                begin
                    s_next = nxt(s_reg, mask);
                    j_next = CW'(1);
                end
                else
                begin
                    start_next = s_reg;
                    k_next     = '0;
                    first_next = 1'b1;
                end
            qfe_pkg::ST_L3: ram_raddr = s_reg;
            qfe_pkg::ST_L3W:
                if (j_lt_n && rd_cont)
                begin
                    s_next = nxt(s_reg, mask);
                    j_next = j_reg + 1'b1;
                end
                else
                begin
                    b_next = nxt(b_reg, mask);
                    j_next = CW'(1);
                end
            qfe_pkg::ST_L4: ram_raddr = b_reg;
            qfe_pkg::ST_L4W:
                if (j_lt_n && !rd_occ)
                begin
                    b_next = nxt(b_reg, mask);
                    j_next = j_reg + 1'b1;
                end
                else
                    k_next = k_reg + 1'b1;
            qfe_pkg::ST_SC: ram_raddr = s_reg;
            qfe_pkg::ST_SCW:
            begin
                first_next = 1'b0;
                head_next  = sc_head;
                if (sc_adv)
                begin
                    s_next = nxt(s_reg, mask);
                    k_next = k_reg + 1'b1;
                end
                if (sc_hit)
                begin
                    case (act_reg)
                        qfe_pkg::ACT_INSERT: code_next = qfe_pkg::OUT_DUPLICATE;
                        qfe_pkg::ACT_LOOKUP: code_next = qfe_pkg::OUT_FOUND;
                        default:             code_next = code_reg;
                    endcase
                    if (act_reg != qfe_pkg::ACT_REMOVE)
                        ans_next = 1'b1;
                end
            end
            qfe_pkg::ST_IP:
            begin
                cm_v = cur_reg;
                if (t_occ && s_reg != start_reg)
                    cm_v[qfe_pkg::FLAG_CONT] = 1'b1;
                if (s_reg != fq_reg)
                    cm_v[qfe_pkg::FLAG_SHIFT] = 1'b1;
                cur_next = cm_v;
                k_next   = '0;
            end
            qfe_pkg::ST_ICONT: ram_raddr = start_reg;
            qfe_pkg::ST_ICONTW:
            begin
                ram_we    = 1'b1;
                ram_waddr = start_reg;
                ram_wdata = ram_rdata | EW'(3'b010);
            end
            qfe_pkg::ST_P: ram_raddr = s_reg;
            qfe_pkg::ST_PW:
            begin
                // occupied flag stays with the home slot, the displaced word moves on
                old_v = ram_rdata;
                cm_v  = cur_reg;
                if (!rd_empty)
                begin
                    old_v[qfe_pkg::FLAG_SHIFT] = 1'b1;
                    if (rd_occ)
                    begin
                        cm_v[qfe_pkg::FLAG_OCC]  = 1'b1;
                        old_v[qfe_pkg::FLAG_OCC] = 1'b0;
                    end
                end
                ram_we    = 1'b1;
                ram_waddr = s_reg;
                ram_wdata = cm_v;
                cur_next  = old_v;
                s_next    = nxt(s_reg, mask);
                k_next    = k_reg + 1'b1;
                code_next = qfe_pkg::OUT_INSERTED;
                ans_next  = 1'b1;
            end
            qfe_pkg::ST_RN: ram_raddr = nxt(s_reg, mask);
            qfe_pkg::ST_RNW:
                if (!rd_cont)
                begin
                    upd_v                    = t_reg;
                    upd_v[qfe_pkg::FLAG_OCC] = 1'b0;
                    t_next                   = upd_v;
                    ram_we                   = 1'b1;
                    ram_waddr                = fq_reg;
                    ram_wdata                = upd_v;
                end
            qfe_pkg::ST_PO0: ram_raddr = s_reg;
            qfe_pkg::ST_PO0W:
            begin
                cur_next  = ram_rdata;
                sp_next   = nxt(s_reg, mask);
                orig_next = s_reg;
            end
            qfe_pkg::ST_PO1: ram_raddr = sp_reg;
            qfe_pkg::ST_PO1W:
                if (po_term)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = s_reg;
                    ram_wdata = '0;
                    code_next = qfe_pkg::OUT_REMOVED;
                    ans_next  = 1'b1;
                end
                else if (po_runstart)
                begin
                    nv_next   = ram_rdata;
                    quot_next = nxt(quot_reg, mask);
                    j_next    = CW'(1);
                end
                else
                begin
                    ram_we    = 1'b1;
                    ram_waddr = s_reg;
                    ram_wdata = {ram_rdata[EW-1:1], cur_reg[qfe_pkg::FLAG_OCC]};
                    s_next    = sp_reg;
                    sp_next   = nxt(sp_reg, mask);
                    cur_next  = ram_rdata;
                end
            qfe_pkg::ST_PO2: ram_raddr = quot_reg;
            qfe_pkg::ST_PO2W:
                if (j_lt_n && !rd_occ)
                begin
                    quot_next = nxt(quot_reg, mask);
                    j_next    = j_reg + 1'b1;
                end
                else
                begin
                    // a run that moves back to its home slot is no longer shifted
                    upd_v = nv_reg;
                    if (cur_reg[qfe_pkg::FLAG_OCC] && quot_reg == s_reg)
                        upd_v[qfe_pkg::FLAG_SHIFT] = 1'b0;
                    ram_we    = 1'b1;
                    ram_waddr = s_reg;
                    ram_wdata = {upd_v[EW-1:1], cur_reg[qfe_pkg::FLAG_OCC]};
                    s_next    = sp_reg;
                    sp_next   = nxt(sp_reg, mask);
                    cur_next  = nv_reg;
                end
            // the removed slot now holds its successor: it heads the run
            qfe_pkg::ST_HD: ram_raddr = orig_reg;
            qfe_pkg::ST_HDW:
            begin
                upd_v                     = ram_rdata;
                upd_v[qfe_pkg::FLAG_CONT] = 1'b0;
                if (orig_reg == fq_reg &&
                    (upd_v[qfe_pkg::FLAG_OCC] || upd_v[qfe_pkg::FLAG_SHIFT]))
                    upd_v[qfe_pkg::FLAG_SHIFT] = 1'b0;
                ram_we    = 1'b1;
                ram_waddr = orig_reg;
                ram_wdata = upd_v;
                code_next = qfe_pkg::OUT_REMOVED;
                ans_next  = 1'b1;
            end
            qfe_pkg::ST_DONE:
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    answer_next      = ans_reg;
                    outcome_next     = code_reg;
                    entry_count_next = count_upd;
                    count_next       = count_upd;
                    clr_pend_next    = 1'b0;
                end
            default: ;
        endcase

        if (cfg_write_en)
        begin
            if (cfg_index)
                r_next = cfg_data;
            else
                q_next = cfg_data[3:0];
            clr_next      = '0;
            clr_pend_next = 1'b0;
            count_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= qfe_pkg::ST_CLEAR;
            q_reg         <= qfe_pkg::CFG_Q_RESET;
            r_reg         <= qfe_pkg::CFG_R_RESET;
            count_reg     <= '0;
            clr_reg       <= '0;
            clr_pend_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            q_reg         <= q_next;
            r_reg         <= r_next;
            count_reg     <= count_next;
            clr_reg       <= clr_next;
            clr_pend_reg  <= clr_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg         <= act_next;
        code_reg        <= code_next;
        ans_reg         <= ans_next;
        fq_reg          <= fq_next;
        fr_reg          <= fr_next;
        t_reg           <= t_next;
        cur_reg         <= cur_next;
        nv_reg          <= nv_next;
        b_reg           <= b_next;
        s_reg           <= s_next;
        start_reg       <= start_next;
        sp_reg          <= sp_next;
        orig_reg        <= orig_next;
        quot_reg        <= quot_next;
        k_reg           <= k_next;
        j_reg           <= j_next;
        first_reg       <= first_next;
        head_reg        <= head_next;
        answer_reg      <= answer_next;
        outcome_reg     <= outcome_next;
        entry_count_reg <= entry_count_next;
    end

    assign out_valid   = out_valid_reg;
    assign answer      = answer_reg;
    assign outcome     = outcome_reg;
    assign entry_count = entry_count_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= n_slots)
        else $error("stored count above table size");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> !in_ready)
        else $error("slot write while accepting words");

    a_clear_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && action == qfe_pkg::ACT_CLEAR) |=>
        (state_reg == qfe_pkg::ST_CLEAR && count_reg == '0))
        else $error("clear word did not start the sweep");

endmodule
`default_nettype wire
